// ===== src/rational_arithmetic_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// implication, same cycle
`define RAU_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("lbl failed");
// implication, next cycle
`define RAU_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("lbl failed");
`endif

// ===== src/rau_pkg.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic unit package
// Word types and operation codes.
// ---------------------------------------------------------------------------
package rau_pkg;
   localparam logic [3:0] FUNC_ADD = 4'd0;
   localparam logic [3:0] FUNC_SUB = 4'd1;
   localparam logic [3:0] FUNC_MUL = 4'd2;
   localparam logic [3:0] FUNC_DIV = 4'd3;
   localparam logic [3:0] FUNC_LT  = 4'd4;
   localparam logic [3:0] FUNC_LE  = 4'd5;
   localparam logic [3:0] FUNC_GT  = 4'd6;
   localparam logic [3:0] FUNC_GE  = 4'd7;
   localparam logic [3:0] FUNC_EQ  = 4'd8;
   localparam logic [3:0] FUNC_NE  = 4'd9;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] a_num;
      logic [31:0]        a_den;
      logic signed [31:0] b_num;
      logic [31:0]        b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [31:0]        res_den;
      logic               cmp_true;
      logic               div_zero;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

// ===== src/rau_divider.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring radix-2 divider, one quotient bit per cycle, 64-bit operands.
// ---------------------------------------------------------------------------
module rau_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [63:0]       dividend,
   input  logic [63:0]       divisor,
   output rau_pkg::div_ctl_type ctl,
   output logic [63:0]       quotient,
   output logic [63:0]       remainder
);
   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[62:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

// ===== src/rational_arithmetic_unit.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add/sub/mul/div with GCD reduction, and fraction compares.
// ---------------------------------------------------------------------------
// One word at a time; requests stall until the response word is taken. Error
// words and unused codes go straight to the output state, compares and zero
// results after the multiply and combine states; arithmetic words then run
// the Euclid remainder steps and the two final divisions, all on the single
// shared 64-bit bit-serial divider; the step count depends on the data (up to
// about ninety steps). Response stalls hold the word in the output state.
module rational_arithmetic_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);
   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001, ST_MUL1 = 10'b0000000010,
      ST_MUL2 = 10'b0000000100, ST_COMB = 10'b0000001000,
      ST_GCD  = 10'b0000010000, ST_GWT  = 10'b0000100000,
      ST_DVN  = 10'b0001000000, ST_DVD  = 10'b0010000000,
      ST_CHK  = 10'b0100000000, ST_OUT  = 10'b1000000000
   } state_type;

   localparam logic [63:0] WMASK = (64'd1 << WORD_BITS) - 64'd1;
   localparam logic [63:0] HALF  = 64'd1 << (WORD_BITS - 1);

   state_type   st_ff, st_in;
   logic [3:0]  fn_ff, fn_in;
   logic signed [63:0] an_ff, an_in, bn_ff, bn_in;
   logic [63:0] ad_ff, ad_in, bd_ff, bd_in;
   logic [31:0] m0a_ff, m0a_in, m0b_ff, m0b_in, m1a_ff, m1a_in, m1b_ff, m1b_in;
   logic [63:0] p_ff, p_in, q_ff, q_in;
   logic        pn_ff, pn_in, qn_ff, qn_in, neg_ff, neg_in;
   logic [63:0] mag_ff, mag_in, den_ff, den_in, x_ff, x_in, y_ff, y_in;
   rau_pkg::rsp_type out_ff, out_in;
   logic        ov_ff, ov_in;

   logic        dv_start;
   logic [63:0] dv_a, dv_b, dv_q, dv_r;
   rau_pkg::div_ctl_type dv_ctl;

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_a),
      .divisor(dv_b), .ctl(dv_ctl), .quotient(dv_q), .remainder(dv_r)
   );

   logic [WORD_BITS-1:0] an_w, bn_w, ad_w, bd_w;
   logic signed [63:0] an_x, bn_x, lhs, rhs;
   logic [63:0] an_m, bn_m, mg;
   logic        c;
   logic [64:0] sum;

   always_comb begin
      an_w = req_data.a_num[WORD_BITS-1:0];
      bn_w = req_data.b_num[WORD_BITS-1:0];
      ad_w = req_data.a_den[WORD_BITS-1:0];
      bd_w = req_data.b_den[WORD_BITS-1:0];
      an_x = 64'(signed'(an_w));
      bn_x = 64'(signed'(bn_w));
      an_m = an_ff[63] ? 64'(-an_ff) : 64'(an_ff);
      bn_m = bn_ff[63] ? 64'(-bn_ff) : 64'(bn_ff);
      lhs = signed'(p_ff); rhs = signed'(q_ff);
      sum = '0; mg = '0; c = 1'b0;
      st_in = st_ff; fn_in = fn_ff;
      an_in = an_ff; bn_in = bn_ff; ad_in = ad_ff; bd_in = bd_ff;
      m0a_in = m0a_ff; m0b_in = m0b_ff; m1a_in = m1a_ff; m1b_in = m1b_ff;
      p_in = p_ff; q_in = q_ff; pn_in = pn_ff; qn_in = qn_ff; neg_in = neg_ff;
      mag_in = mag_ff; den_in = den_ff; x_in = x_ff; y_in = y_ff;
      out_in = out_ff; ov_in = ov_ff;
      dv_start = 1'b0; dv_a = x_ff; dv_b = y_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fn_in = req_data.func;
               an_in = an_x; bn_in = bn_x;
               ad_in = 64'(ad_w); bd_in = 64'(bd_w);
               out_in = '0; out_in.res_den = 32'd1;
               if (req_data.func > rau_pkg::FUNC_NE) begin
                  st_in = ST_OUT;
               end else if (ad_w == '0 || bd_w == '0 ||
                            (req_data.func == rau_pkg::FUNC_DIV && bn_w == '0)) begin
                  out_in.div_zero = 1'b1; st_in = ST_OUT;
               end else begin
                  st_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            // operand magnitudes for two unsigned 32x32 products
            pn_in = an_ff[63]; qn_in = bn_ff[63];
            case (fn_ff)
               rau_pkg::FUNC_MUL: begin
                  m0a_in = an_m[31:0]; m0b_in = bn_m[31:0];
                  m1a_in = ad_ff[31:0]; m1b_in = bd_ff[31:0];
               end
               rau_pkg::FUNC_DIV: begin
                  m0a_in = an_m[31:0]; m0b_in = bd_ff[31:0];
                  m1a_in = ad_ff[31:0]; m1b_in = bn_m[31:0];
               end
               default: begin
                  m0a_in = an_m[31:0]; m0b_in = bd_ff[31:0];
                  m1a_in = bn_m[31:0]; m1b_in = ad_ff[31:0];
               end
            endcase
            st_in = ST_MUL2;
         end
         ST_MUL2: begin
            p_in = 64'(m0a_ff) * 64'(m0b_ff);
            q_in = 64'(m1a_ff) * 64'(m1b_ff);
            st_in = ST_COMB;
         end
         ST_COMB: begin
            lhs = pn_ff ? signed'(64'(-p_ff)) : signed'(p_ff);
            rhs = qn_ff ? signed'(64'(-q_ff)) : signed'(q_ff);
            case (fn_ff)
               rau_pkg::FUNC_LT: c = lhs < rhs;
               rau_pkg::FUNC_LE: c = lhs <= rhs;
               rau_pkg::FUNC_GT: c = lhs > rhs;
               rau_pkg::FUNC_GE: c = lhs >= rhs;
               rau_pkg::FUNC_EQ: c = lhs == rhs;
               default:          c = lhs != rhs;
            endcase
            if (fn_ff >= rau_pkg::FUNC_LT) begin
               out_in.cmp_true = c; st_in = ST_OUT;
            end else begin
               if (fn_ff == rau_pkg::FUNC_MUL || fn_ff == rau_pkg::FUNC_DIV) begin
                  mg = p_ff; neg_in = pn_ff ^ qn_ff; den_in = q_ff;
               end else begin
                  den_in = 64'(ad_ff[31:0]) * 64'(bd_ff[31:0]);
                  if (pn_ff == (qn_ff ^ (fn_ff == rau_pkg::FUNC_SUB))) begin
                     sum = {1'b0, p_ff} + {1'b0, q_ff};
                     mg = sum[63:0]; neg_in = pn_ff;
                  end else if (p_ff >= q_ff) begin
                     mg = p_ff - q_ff; neg_in = pn_ff;
                  end else begin
                     mg = q_ff - p_ff; neg_in = ~pn_ff;
                  end
               end
               mag_in = mg;
               if (mg == '0) begin
                  st_in = ST_OUT;
               end else begin
                  x_in = mg; y_in = den_in; st_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (y_ff == '0) begin
               dv_a = mag_ff; dv_b = x_ff; dv_start = 1'b1; st_in = ST_DVN;
            end else begin
               dv_start = 1'b1; st_in = ST_GWT;
            end
         end
         ST_GWT: begin
            if (dv_ctl.done) begin
               x_in = y_ff; y_in = dv_r; st_in = ST_GCD;
            end
         end
         ST_DVN: begin
            if (dv_ctl.done) begin
               mag_in = dv_q; dv_a = den_ff; dv_b = x_ff; dv_start = 1'b1;
               st_in = ST_DVD;
            end
         end
         ST_DVD: begin
            if (dv_ctl.done) begin
               den_in = dv_q; st_in = ST_CHK;
            end
         end
         ST_CHK: begin
            ov_in = den_ff > WMASK || (neg_ff ? mag_ff > HALF : mag_ff > HALF - 64'd1);
            if (ov_in) begin
               out_in.overflow = 1'b1;
            end else begin
               mg = neg_ff ? 64'(-mag_ff) : mag_ff;
               out_in.res_num = mg[31:0];
               out_in.res_den = den_ff[31:0];
            end
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      fn_ff <= fn_in; an_ff <= an_in; bn_ff <= bn_in; ad_ff <= ad_in; bd_ff <= bd_in;
      m0a_ff <= m0a_in; m0b_ff <= m0b_in; m1a_ff <= m1a_in; m1b_ff <= m1b_in;
      p_ff <= p_in; q_ff <= q_in; pn_ff <= pn_in; qn_ff <= qn_in; neg_ff <= neg_in;
      mag_ff <= mag_in; den_ff <= den_in; x_ff <= x_in; y_ff <= y_in;
      out_ff <= out_in; ov_ff <= ov_in;
   end

   assign req_stall = (st_ff != ST_IDLE);
   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_data = out_ff;
endmodule

// ===== src/rau_checker.sv =====
// ---------------------------------------------------------------------------
// Rational arithmetic unit checker
// Port-level temporal checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"
module rau_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rau_pkg::rsp_type rsp_data
);
   `RAU_ASSERT_IMP(a_busy_out, clock, reset, rsp_valid, req_stall)
   `RAU_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `RAU_ASSERT_IMP(a_flags, clock, reset, rsp_valid, !(rsp_data.div_zero && rsp_data.overflow))
   `RAU_ASSERT_NXT(a_take, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

// ===== tb/sv/rational_arithmetic_unit_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches the request and response channels, computes the expected reduced
// fraction or compare outcome for every accepted word, and compares each
// response field with the oldest expected word.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  rau_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rau_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   rau_pkg::rsp_type expected_q[$];

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic rau_pkg::rsp_type fraction_result(rau_pkg::req_type q);
      rau_pkg::rsp_type o;
      logic signed [63:0] an, bn, l, r;
      logic [63:0] ad, bd, pm, qm, mag, den, g;
      logic pn, qn, neg;
      o = '{res_num: 0, res_den: 1, cmp_true: 0, div_zero: 0, overflow: 0};
      an = 64'(q.a_num);
      bn = 64'(q.b_num);
      ad = {32'd0, q.a_den};
      bd = {32'd0, q.b_den};
      if (q.func > rau_pkg::FUNC_NE) return o;
      if (ad == 0 || bd == 0 || (q.func == rau_pkg::FUNC_DIV && bn == 0)) begin
         o.div_zero = 1;
         return o;
      end
      if (q.func >= rau_pkg::FUNC_LT) begin
         l = an * $signed(bd);
         r = $signed(ad) * bn;
         case (q.func)
            rau_pkg::FUNC_LT: o.cmp_true = l < r;
            rau_pkg::FUNC_LE: o.cmp_true = l <= r;
            rau_pkg::FUNC_GT: o.cmp_true = l > r;
            rau_pkg::FUNC_GE: o.cmp_true = l >= r;
            rau_pkg::FUNC_EQ: o.cmp_true = l == r;
            default: o.cmp_true = l != r;
         endcase
         return o;
      end
      if (q.func == rau_pkg::FUNC_ADD || q.func == rau_pkg::FUNC_SUB) begin
         l = an * $signed(bd);
         r = bn * $signed(ad);
         pn = l < 0;
         qn = r < 0;
         pm = pn ? -l : l;
         qm = qn ? -r : r;
         if (q.func == rau_pkg::FUNC_SUB) qn = !qn;
         if (pn == qn) begin
            mag = pm + qm;
            neg = pn;
         end else if (pm >= qm) begin
            mag = pm - qm;
            neg = pn;
         end else begin
            mag = qm - pm;
            neg = qn;
         end
         den = ad * bd;
      end else begin
         pm = an < 0 ? -an : an;
         qm = bn < 0 ? -bn : bn;
         neg = (an < 0) != (bn < 0);
         if (q.func == rau_pkg::FUNC_MUL) begin
            mag = pm * qm;
            den = ad * bd;
         end else begin
            mag = pm * bd;
            den = ad * qm;
         end
      end
      if (mag == 0) return o;
      g = gcd64(mag, den);
      mag = mag / g;
      den = den / g;
      if (den > 64'hFFFF_FFFF || (neg ? mag > 64'h8000_0000 : mag > 64'h7FFF_FFFF)) begin
         o.overflow = 1;
         return o;
      end
      mag = neg ? -mag : mag;
      o.res_num = mag[31:0];
      o.res_den = den[31:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rau_pkg::rsp_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) expected_q.push_back(fraction_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected response word %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e != rsp_data) fail_count <= fail_count + 1;
               if (e.res_num != rsp_data.res_num)
                  $error("res_num exp %0d got %0d", e.res_num, rsp_data.res_num);
               if (e.res_den != rsp_data.res_den)
                  $error("res_den exp %0d got %0d", e.res_den, rsp_data.res_den);
               if (e.cmp_true != rsp_data.cmp_true)
                  $error("cmp_true exp %0b got %0b", e.cmp_true, rsp_data.cmp_true);
               if (e.div_zero != rsp_data.div_zero)
                  $error("div_zero exp %0b got %0b", e.div_zero, rsp_data.div_zero);
               if (e.overflow != rsp_data.overflow)
                  $error("overflow exp %0b got %0b", e.overflow, rsp_data.overflow);
            end
         end
      end
      pending_count <= expected_q.size();
   end
endmodule

// ===== tb/sv/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed and random fraction words with random idle bursts on both
// channels; the checker predicts and compares, this top gives the verdict.
// ---------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   rau_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rau_pkg::rsp_type rsp_data;
   int               fail_count;
   int               pending_count;
   bit               calm;

   rational_arithmetic_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   rational_arithmetic_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2000ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // response-side stall bursts
   initial begin
      int n;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 18);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'(int'($urandom_range(0, 20)) - 10);
         4: return $urandom_range(0, 1000);
         5: return 32'(1) << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_den();
      if ($urandom_range(0, 39) == 0) return '0;
      if ($urandom_range(0, 3) == 0) return pick_word();
      return $urandom_range(1, 5000);
   endfunction

   task automatic send_word(rau_pkg::req_type w);
      int n;
      if (!calm && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 18);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_fraction(logic [3:0] f, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
      rau_pkg::req_type w;
      w.func = f;
      w.a_num = an;
      w.a_den = ad;
      w.b_num = bn;
      w.b_den = bd;
      send_word(w);
   endtask

   initial begin
      rau_pkg::req_type w;
      int k;
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_fraction(rau_pkg::FUNC_ADD, 1, 2, 1, 3);
      send_fraction(rau_pkg::FUNC_SUB, 1, 2, 1, 2);
      send_fraction(rau_pkg::FUNC_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
      send_fraction(rau_pkg::FUNC_DIV, 3, 4, -5, 7);
      send_fraction(rau_pkg::FUNC_DIV, 3, 4, 0, 7);
      send_fraction(rau_pkg::FUNC_LT, -1, 2, 1, 3);
      send_fraction(rau_pkg::FUNC_LE, 2, 4, 1, 2);
      send_fraction(rau_pkg::FUNC_GT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, -1, 1);
      send_fraction(rau_pkg::FUNC_GE, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
      send_fraction(rau_pkg::FUNC_EQ, 2, 4, 1, 2);
      send_fraction(rau_pkg::FUNC_NE, 2, 4, 1, 2);
      send_fraction(rau_pkg::FUNC_ADD, 0, 5, 0, 9);
      send_fraction(rau_pkg::FUNC_ADD, 1, 0, 1, 2);
      send_fraction(rau_pkg::FUNC_LT, 1, 2, 1, 0);
      send_fraction(rau_pkg::FUNC_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
      send_fraction(rau_pkg::FUNC_MUL, 1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      send_fraction(rau_pkg::FUNC_SUB, 32'h8000_0000, 1, 0, 1);
      send_fraction(rau_pkg::FUNC_DIV, 32'h8000_0000, 1, -1, 1);
      send_fraction(4'd10, 1, 1, 1, 1);
      send_fraction(4'd15, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (k = 0; k < 1530; k++) begin
         if (k == 1300) calm = 1;
         w.func  = $urandom_range(0, 19) == 0 ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
         w.a_num = pick_word();
         w.a_den = pick_den();
         w.b_num = pick_word();
         w.b_den = pick_den();
         send_word(w);
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
